[rtl/gregorian_date_step_and_diff_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian date stepper and day counter
// Implication forms, same cycle and next cycle, with async reset disable.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_STEP_AND_DIFF_ASSERT_SVH
`define GREGORIAN_DATE_STEP_AND_DIFF_ASSERT_SVH

`define GDSD_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error(MSG);

`define GDSD_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

[rtl/gdsd_pkg.sv]
// ----------------------------------------------------------------------------
// gdsd_pkg
// Shared types, step codes and calendar helper functions.
// ----------------------------------------------------------------------------
package gdsd_pkg;

	localparam int DN_W = 23;
	localparam int CNT_W = 22;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [2:0] WDAY_SUN = 3'd6;

	localparam logic [2:0] STEP_NONE = 3'd0;
	localparam logic [2:0] STEP_Q0 = 3'd1;
	localparam logic [2:0] STEP_Q1 = 3'd2;
	localparam logic [2:0] STEP_Q2 = 3'd3;
	localparam logic [2:0] STEP_Q3 = 3'd4;
	localparam logic [2:0] STEP_ADV = 3'd5;
	localparam logic [2:0] STEP_DIFF = 3'd6;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic load;
		logic sel_b;
		logic [2:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
	} dp_stat_t;

	// floor(x / 100), exact for x below 25600
	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'd5243;
		return p[26:19];
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = leap ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd2: r = 9'd31;
			4'd3: r = 9'd59;
			4'd4: r = 9'd90;
			4'd5: r = 9'd120;
			4'd6: r = 9'd151;
			4'd7: r = 9'd181;
			4'd8: r = 9'd212;
			4'd9: r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/gregorian_date_step_and_diff.sv]
// ----------------------------------------------------------------------------
// gregorian_date_step_and_diff
// Gregorian date stepper (opcode 0) and day counter between two dates
// (opcode 1). A request is taken when start is high and busy is low. The
// result appears for one cycle with done high and cannot be held off, so
// it must be captured then. Advance: busy through states A0, A1 and ADV;
// the result is registered when ADV ends and done is high in the cycle
// after it. Count: busy through A0 to A3, B0 to B3 and DIFF; the result
// is registered when DIFF ends. Each date is turned into a
// day number over four steps that share one divide-by-100 multiplier, then
// one subtract. A new request may be issued in the cycle that done is high.
// ----------------------------------------------------------------------------
module gregorian_date_step_and_diff (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [4:0]  day_a,
	input  logic [3:0]  month_a,
	input  logic [13:0] year_a,
	input  logic [2:0]  weekday_a,
	input  logic [4:0]  day_b,
	input  logic [3:0]  month_b,
	input  logic [13:0] year_b,
	output logic        done,
	output logic [4:0]  next_day,
	output logic [3:0]  next_month,
	output logic [13:0] next_year,
	output logic [2:0]  next_weekday,
	output logic [21:0] day_count,
	output logic        overflow
);
	import gdsd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gdsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	gdsd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.day_a        (day_a),
		.month_a      (month_a),
		.year_a       (year_a),
		.weekday_a    (weekday_a),
		.day_b        (day_b),
		.month_b      (month_b),
		.year_b       (year_b),
		.next_day     (next_day),
		.next_month   (next_month),
		.next_year    (next_year),
		.next_weekday (next_weekday),
		.day_count    (day_count),
		.overflow     (overflow),
		.done         (done)
	);

endmodule

[rtl/gdsd_ctrl.sv]
// ----------------------------------------------------------------------------
// gdsd_ctrl
// Sequencer: issues datapath steps for advance and day count requests.
// ----------------------------------------------------------------------------
module gdsd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gdsd_pkg::dp_stat_t stat,
	output logic               busy,
	output gdsd_pkg::dp_cmd_t  cmd
);
	import gdsd_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_A0 = 4'd1;
	localparam logic [3:0] ST_A1 = 4'd2;
	localparam logic [3:0] ST_A2 = 4'd3;
	localparam logic [3:0] ST_A3 = 4'd4;
	localparam logic [3:0] ST_B0 = 4'd5;
	localparam logic [3:0] ST_B1 = 4'd6;
	localparam logic [3:0] ST_B2 = 4'd7;
	localparam logic [3:0] ST_B3 = 4'd8;
	localparam logic [3:0] ST_ADV = 4'd9;
	localparam logic [3:0] ST_DIFF = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd.load = 1'b0;
		cmd.sel_b = 1'b0;
		cmd.step = STEP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = ST_A0;
				end
			end
			ST_A0: begin
				cmd.step = STEP_Q0;
				state_nxt = ST_A1;
			end
			ST_A1: begin
				cmd.step = STEP_Q1;
				state_nxt = stat.op ? ST_A2 : ST_ADV;
			end
			ST_A2: begin
				cmd.step = STEP_Q2;
				state_nxt = ST_A3;
			end
			ST_A3: begin
				cmd.step = STEP_Q3;
				state_nxt = ST_B0;
			end
			ST_B0: begin
				cmd.step = STEP_Q0;
				cmd.sel_b = 1'b1;
				state_nxt = ST_B1;
			end
			ST_B1: begin
				cmd.step = STEP_Q1;
				cmd.sel_b = 1'b1;
				state_nxt = ST_B2;
			end
			ST_B2: begin
				cmd.step = STEP_Q2;
				cmd.sel_b = 1'b1;
				state_nxt = ST_B3;
			end
			ST_B3: begin
				cmd.step = STEP_Q3;
				cmd.sel_b = 1'b1;
				state_nxt = ST_DIFF;
			end
			ST_ADV: begin
				cmd.step = STEP_ADV;
				state_nxt = ST_IDLE;
			end
			ST_DIFF: begin
				cmd.step = STEP_DIFF;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/gdsd_dp.sv]
// ----------------------------------------------------------------------------
// gdsd_dp
// Datapath: operand capture, day number build with a shared divide by 100,
// next-date logic and result registers.
// ----------------------------------------------------------------------------
module gdsd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  gdsd_pkg::dp_cmd_t  cmd,
	output gdsd_pkg::dp_stat_t stat,
	input  logic               opcode,
	input  logic [4:0]         day_a,
	input  logic [3:0]         month_a,
	input  logic [13:0]        year_a,
	input  logic [2:0]         weekday_a,
	input  logic [4:0]         day_b,
	input  logic [3:0]         month_b,
	input  logic [13:0]        year_b,
	output logic [4:0]         next_day,
	output logic [3:0]         next_month,
	output logic [13:0]        next_year,
	output logic [2:0]         next_weekday,
	output logic [21:0]        day_count,
	output logic               overflow,
	output logic               done
);
	import gdsd_pkg::*;

	logic            op_q;
	logic [4:0]      da_q, db_q;
	logic [3:0]      ma_q, mb_q;
	logic [13:0]     ya_q, yb_q;
	logic [2:0]      wa_q;
	logic            a_first_q;
	logic [7:0]      r0_q, r1_q;
	logic [7:0]      r2_q;
	logic            leap_q;
	logic [DN_W-1:0] base_q;
	logic [DN_W-1:0] dn_a_q, dn_b_q;

	logic [4:0]      nd_q;
	logic [3:0]      nm_q;
	logic [13:0]     ny_q;
	logic [2:0]      nw_q;
	logic [CNT_W-1:0] cnt_q;
	logic            ov_q;
	logic            done_q;

	logic [13:0]     y_s;
	logic [3:0]      m_s, mc;
	logic [4:0]      d_s;
	logic [14:0]     div_in;
	logic [7:0]      quo;
	logic [14:0]     hund;
	logic            c100, leap_c;
	logic            a_first_c;
	logic [4:0]      len_a;
	logic [DN_W-1:0] hi, lo;
	logic [DN_W:0]   diff;
	logic [CNT_W-1:0] cnt_c;

	assign stat.op = op_q;

	assign y_s = cmd.sel_b ? yb_q : ya_q;
	assign m_s = cmd.sel_b ? mb_q : ma_q;
	assign d_s = cmd.sel_b ? db_q : da_q;

	always_comb begin
		if (m_s < MON_JAN) begin
			mc = MON_JAN;
		end else if (m_s > MON_DEC) begin
			mc = MON_DEC;
		end else begin
			mc = m_s;
		end
	end

	always_comb begin
		case (cmd.step)
			STEP_Q1: div_in = 15'(y_s) + 15'd99;
			STEP_Q2: div_in = 15'((15'(y_s) + 15'd399) >> 2);
			default: div_in = 15'(y_s);
		endcase
	end

	assign quo = div100(div_in);

	// leap from y / 100 held in r0_q
	assign hund = 15'(r0_q) * 15'd100;
	assign c100 = (hund == 15'(y_s));
	assign leap_c = ((y_s[1:0] == 2'd0) && !c100) || (c100 && (r0_q[1:0] == 2'd0));

	always_comb begin
		if (year_a != year_b) begin
			a_first_c = (year_a < year_b);
		end else if (month_a != month_b) begin
			a_first_c = (month_a < month_b);
		end else begin
			a_first_c = (day_a <= day_b);
		end
	end

	assign len_a = month_len(ma_q, leap_q);

	assign hi = a_first_q ? dn_b_q : dn_a_q;
	assign lo = a_first_q ? dn_a_q : dn_b_q;
	assign diff = {1'b0, hi} - {1'b0, lo};

	always_comb begin
		if (diff[DN_W]) begin
			cnt_c = '0;
		end else if (diff[DN_W-1]) begin
			cnt_c = '1;
		end else begin
			cnt_c = diff[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			da_q <= day_a;
			ma_q <= month_a;
			ya_q <= year_a;
			wa_q <= weekday_a;
			db_q <= day_b;
			mb_q <= month_b;
			yb_q <= year_b;
			a_first_q <= a_first_c;
		end
		case (cmd.step)
			STEP_Q0: begin
				r0_q <= quo;
				base_q <= DN_W'(y_s) * DN_W'(365) + DN_W'((15'(y_s) + 15'd3) >> 2);
			end
			STEP_Q1: begin
				r1_q <= quo;
				leap_q <= leap_c;
			end
			STEP_Q2: begin
				r2_q <= quo;
				base_q <= base_q - DN_W'(r1_q) + DN_W'(days_before(mc))
					+ DN_W'(leap_q && (mc > MON_FEB)) + DN_W'(d_s);
			end
			STEP_Q3: begin
				if (cmd.sel_b) begin
					dn_b_q <= base_q + DN_W'(r2_q);
				end else begin
					dn_a_q <= base_q + DN_W'(r2_q);
				end
			end
			STEP_ADV: begin
				nw_q <= (wa_q >= WDAY_SUN) ? 3'd0 : wa_q + 3'd1;
				cnt_q <= '0;
				ov_q <= 1'b0;
				nm_q <= ma_q;
				ny_q <= ya_q;
				if (da_q < len_a) begin
					nd_q <= da_q + 5'd1;
				end else begin
					nd_q <= 5'd1;
					if (ma_q >= MON_DEC) begin
						nm_q <= MON_JAN;
						if (ya_q >= YEAR_MAX) begin
							ov_q <= 1'b1;
							ny_q <= YEAR_MAX;
						end else begin
							ny_q <= ya_q + 14'd1;
						end
					end else begin
						nm_q <= ma_q + 4'd1;
					end
				end
			end
			STEP_DIFF: begin
				nd_q <= '0;
				nm_q <= '0;
				ny_q <= '0;
				nw_q <= '0;
				ov_q <= 1'b0;
				cnt_q <= cnt_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.step == STEP_ADV) || (cmd.step == STEP_DIFF);
		end
	end

	assign next_day = nd_q;
	assign next_month = nm_q;
	assign next_year = ny_q;
	assign next_weekday = nw_q;
	assign day_count = cnt_q;
	assign overflow = ov_q;
	assign done = done_q;

endmodule

[rtl/gdsd_chk.sv]
// ----------------------------------------------------------------------------
// gdsd_chk
// Port-level checks for the date stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_date_step_and_diff_assert.svh"

module gdsd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        opcode,
	input logic [4:0]  day_a,
	input logic [3:0]  month_a,
	input logic [13:0] year_a,
	input logic [2:0]  weekday_a,
	input logic [4:0]  day_b,
	input logic [3:0]  month_b,
	input logic [13:0] year_b,
	input logic        done,
	input logic [4:0]  next_day,
	input logic [3:0]  next_month,
	input logic [13:0] next_year,
	input logic [2:0]  next_weekday,
	input logic [21:0] day_count,
	input logic        overflow
);
	import gdsd_pkg::*;

	`GDSD_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted beat did not raise busy")
	`GDSD_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done, "done held longer than one cycle")
	`GDSD_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy), "done without a request in flight")
	`GDSD_ASSERT_IMP(a_one_kind, clk, arst_n, done, (day_count == 22'd0) || ((next_day == 5'd0) && (next_month == 4'd0) && (next_year == 14'd0) && (next_weekday == 3'd0) && !overflow), "result mixes advance and count fields")
	`GDSD_ASSERT_IMP(a_ovf_sat, clk, arst_n, done && overflow, (next_day == 5'd1) && (next_month == MON_JAN) && (next_year == YEAR_MAX), "overflow without saturated date")

endmodule

bind gregorian_date_step_and_diff gdsd_chk u_chk (.*);
